FILE: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Request kinds, status codes, stream field widths and the control word
// that the top level sends along each chain of cells.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Width of the value fields on the stream ports
  localparam int unsigned VALUE_W = 32;
  // Width of the reported occupancy
  localparam int unsigned OCC_W = 8;
  // Width used for sign extension of stored entries (widest DATA_WIDTH)
  localparam int unsigned EXT_W = 64;
  // Result tdata: pop_value, occupancy, is_empty, is_full, padded to bytes
  localparam int unsigned RES_TDATA_W = 48;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } cdq_kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_PUSH_FULL  = 2'd1,
    STATUS_POP_EMPTY  = 2'd2,
    STATUS_RESERVED   = 2'd3
  } cdq_status_e;

  // Per-chain move: shift towards the far end (insert at cell 0),
  // shift towards cell 0 (drop cell 0), or write the cell at the fill count.
  typedef struct packed {
    logic shift_in;
    logic shift_out;
    logic write_at_count;
  } cdq_ctl_t;

endpackage

FILE: sv/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of a deque chain
// Holds one entry; loads from its left or right neighbour on a shift, or
// the new value when the chain writes at this cell's position.
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 8,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  cdq_ctl_t              ctl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;
  logic                  load;

  always_comb begin
    load   = 1'b1;
    data_d = data_q;
    if (ctl_i.shift_in) begin
      data_d = left_i;
    end else if (ctl_i.shift_out) begin
      data_d = right_i;
    end else if (ctl_i.write_at_count && (count_i == MyIdx)) begin
      data_d = value_i;
    end else begin
      load = 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

FILE: sv/cdq_chain.sv
// ----------------------------------------------------------------------------
// cdq_chain: row of deque cells, end entry always at cell 0
// Cell 0 takes the new value on an insert; cells past the fill count hold
// stale data that is never read.
// ----------------------------------------------------------------------------
module cdq_chain
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 8
) (
  input  logic                  clk_i,
  input  cdq_ctl_t              ctl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic [DATA_WIDTH-1:0] head_o
);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    cdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .count_i (count_i),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

FILE: sv/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue built from two chains of cells
// Push or pop at either end; every request yields one result carrying the
// popped value, a status code, the occupancy and empty/full flags.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: push_value[31:0]
//                                                tuser: kind[1:0]
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: pop_value[31:0],
//                                                occupancy[39:32],
//                                                is_empty[40], is_full[41]
//                                                tuser: status[1:0]
//
//  One request per cycle: a request is resolved in the cycle it is accepted
//  and its result is registered; the next request may enter straight away.
//  The result is valid in the cycle after the input transaction.
//  The only stall comes from the output register: input is taken while the
//  result slot is empty or being drained in the same cycle.
//  Reset clears the occupancy and the result slot; no clearing pass is run,
//  stored entries are undefined until pushed.
//
// Organisation: chain A holds the entries front..rear from cell 0, chain B
// holds the same entries rear..front from cell 0. Both ends are therefore
// always at cell 0 of one chain. A push at one end shifts that end's chain
// and writes the other chain at the cell given by the current count; a pop
// shifts the chain it reads and merely shortens the other.
// ----------------------------------------------------------------------------
module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VALUE_W-1:0]     s_axis_tdata,  // [31:0] push_value
  input  logic [1:0]             s_axis_tuser,  // [1:0] kind
  // result side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [RES_TDATA_W-1:0] m_axis_tdata,  // [31:0] pop_value, [39:32] occupancy,
                                                // [40] is_empty, [41] is_full, rest 0
  output logic [1:0]             m_axis_tuser   // [1:0] status
);

  // count must also hold DEPTH itself
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FullCount = CNT_W'(DEPTH);
  localparam int unsigned PAD_W = RES_TDATA_W - VALUE_W - OCC_W - 2;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  cdq_kind_e                 kind;
  logic signed [VALUE_W-1:0] push_value;
  logic signed [EXT_W-1:0]   push_ext;
  logic [DATA_WIDTH-1:0]     store_value;
  logic                      in_accept;

  assign kind        = cdq_kind_e'(s_axis_tuser);
  assign push_value  = s_axis_tdata;
  assign push_ext    = EXT_W'(push_value);          // sign extension
  assign store_value = push_ext[DATA_WIDTH-1:0];

  logic                      out_valid_q;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Occupancy and chain control
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             is_empty_now;
  logic             is_full_now;
  cdq_ctl_t         ctl_a;
  cdq_ctl_t         ctl_b;
  cdq_status_e      status;
  logic             take_a;     // popped value comes from chain A
  logic             pop_done;

  assign is_empty_now = (count_q == '0);
  assign is_full_now  = (count_q == FullCount);

  always_comb begin
    ctl_a    = '0;
    ctl_b    = '0;
    count_d  = count_q;
    status   = STATUS_DONE;
    take_a   = 1'b0;
    pop_done = 1'b0;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (is_full_now) begin
          status = STATUS_PUSH_FULL;
        end else begin
          ctl_a.shift_in       = in_accept;
          ctl_b.write_at_count = in_accept;
          count_d              = count_q + 1'b1;
        end
      end
      KIND_PUSH_REAR: begin
        if (is_full_now) begin
          status = STATUS_PUSH_FULL;
        end else begin
          ctl_b.shift_in       = in_accept;
          ctl_a.write_at_count = in_accept;
          count_d              = count_q + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty_now) begin
          status = STATUS_POP_EMPTY;
        end else begin
          ctl_a.shift_out = in_accept;
          take_a          = 1'b1;
          pop_done        = 1'b1;
          count_d         = count_q - 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (is_empty_now) begin
          status = STATUS_POP_EMPTY;
        end else begin
          ctl_b.shift_out = in_accept;
          pop_done        = 1'b1;
          count_d         = count_q - 1'b1;
        end
      end
      default: begin
        status = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_accept) begin
      count_q <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chains: A front-first, B rear-first
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] head_a;
  logic [DATA_WIDTH-1:0] head_b;

  cdq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_chain_a (
    .clk_i   (clk_i),
    .ctl_i   (ctl_a),
    .count_i (count_q),
    .value_i (store_value),
    .head_o  (head_a)
  );

  cdq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_chain_b (
    .clk_i   (clk_i),
    .ctl_i   (ctl_b),
    .count_i (count_q),
    .value_i (store_value),
    .head_o  (head_b)
  );

  // --------------------------------------------------------------------------
  // Result formation and output register
  // --------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] rd_entry;
  logic signed [EXT_W-1:0]      rd_ext;
  logic [VALUE_W-1:0]           pop_value;
  logic [RES_TDATA_W-1:0]       res_tdata;

  assign rd_entry  = take_a ? head_a : head_b;
  assign rd_ext    = EXT_W'(rd_entry);              // sign extension
  assign pop_value = pop_done ? rd_ext[VALUE_W-1:0] : '0;
  assign res_tdata = {PAD_W'(0), (count_d == FullCount), (count_d == '0),
                      OCC_W'(count_d), pop_value};

  logic [RES_TDATA_W-1:0] out_data_q;
  logic [1:0]             out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= res_tdata;
      out_user_q <= status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("occupancy beyond depth");

  a_count_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(count_q))
    else $error("occupancy moved without a transaction");

  a_refused_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && status != STATUS_DONE) |=> $stable(count_q))
    else $error("refused request changed occupancy");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  a_empty_pop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == STATUS_POP_EMPTY)
      |-> (m_axis_tdata[VALUE_W-1:0] == '0 && m_axis_tdata[VALUE_W+OCC_W]))
    else $error("refused pop reported a value or a non-empty store");

endmodule
